/* sv/stl_pkg.sv */
// stl_pkg: shared types, token kind codes and keyword table of the script token lexer.
// No dependencies.
`timescale 1ns / 1ps
package stl_pkg;

    localparam int SOURCE_BYTES = 65536;
    localparam logic [15:0] POS_MAX = (SOURCE_BYTES - 1 < 65535) ?
                                      16'(SOURCE_BYTES - 1) : 16'hFFFF;

    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_OPEQ0   = 6'd10;
    localparam logic [5:0] K_OP0     = 6'd11;
    localparam logic [5:0] K_SLASH   = 6'd18;
    localparam logic [5:0] K_STRING  = 6'd19;
    localparam logic [5:0] K_NUMBER  = 6'd20;
    localparam logic [5:0] K_IDENT   = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_END     = 6'd39;
    localparam logic [5:0] K_BADCHAR = 6'd40;
    localparam logic [5:0] K_UNTERM  = 6'd41;

    localparam int NUM_KW = 17;

    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'("and"), 48'("class"), 48'("false"), 48'("fun"), 48'("for"),
        48'("while"), 48'("if"), 48'("else"), 48'("nil"), 48'("or"),
        48'("print"), 48'("return"), 48'("super"), 48'("this"), 48'("true"),
        48'("var"), 48'("break")
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd5, 3'd3, 3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd2,
        3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } t_tok;

    // All tokens caused by one input word; cnt is 1..4 when queued.
    typedef struct packed {
        t_tok [3:0] tok;
        logic [2:0] cnt;
    } t_bundle;

    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

    function automatic logic [5:0] kw_kind(input logic [47:0] b, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if (n == KW_LEN[i] && b == KW_TEXT[i]) k = 6'(K_KW0 + 6'(i));
        end
        return k;
    endfunction

endpackage

/* sv/stl_in_if.sv */
// stl_in_if: source byte channel of the script token lexer.
// No dependencies.
`timescale 1ns / 1ps
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       no_char;
    logic       is_last;
    modport source (output valid, char_code, no_char, is_last, input ready);
    modport sink   (input valid, char_code, no_char, is_last, output ready);
endinterface

/* sv/stl_out_if.sv */
// stl_out_if: token channel of the script token lexer.
// No dependencies.
`timescale 1ns / 1ps
interface stl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
    modport source (output valid, token_kind, start_offset, token_length, line_number,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, start_offset, token_length, line_number,
                    last_of_run, output ready);
endinterface

/* sv/stl_front.sv */
// stl_front: scanner state machine; turns one byte word into a bundle of tokens.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char,
    input  logic              i_no_char,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output stl_pkg::t_bundle  o_bundle
);
    import stl_pkg::*;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_OP      = 4'd1;
    localparam logic [3:0] M_SLASH   = 4'd2;
    localparam logic [3:0] M_COMMENT = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_NUM     = 4'd5;
    localparam logic [3:0] M_NUMDOT  = 4'd6;
    localparam logic [3:0] M_FRAC    = 4'd7;
    localparam logic [3:0] M_IDENT   = 4'd8;

    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_ts, n_ts;
    logic [15:0] r_line, n_line;
    logic [1:0]  r_op, n_op;
    logic [47:0] r_kb, n_kb;
    logic [2:0]  r_nl, n_nl;

    t_bundle b;
    logic    accept;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction
    function automatic logic [15:0] len_inc(input logic [15:0] d);
        return (d == 16'hFFFF) ? d : d + 16'd1;
    endfunction

    assign accept   = i_valid && o_ready;
    assign o_ready  = !i_full;
    assign o_push   = accept && (b.cnt != 3'd0);
    assign o_bundle = b;

    always_comb begin
        logic [7:0]  c;
        logic [15:0] p;
        logic [15:0] dot;
        logic        rescan;
        c      = i_char;
        p      = r_pos;
        rescan = 1'b0;
        dot    = 16'd0;
        n_mode = r_mode;
        n_pos  = r_pos;
        n_ts   = r_ts;
        n_line = r_line;
        n_op   = r_op;
        n_kb   = r_kb;
        n_nl   = r_nl;
        b      = '0;

        if (!i_no_char) begin
            unique case (r_mode)
                M_OP: begin
                    if (c == "=") begin
                        b.tok[b.cnt[1:0]] = '{K_OPEQ0 + {3'd0, r_op, 1'b0}, r_ts,
                                              len_inc(p - r_ts), r_line};
                        b.cnt = b.cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        b.tok[b.cnt[1:0]] = '{K_OP0 + {3'd0, r_op, 1'b0}, r_ts, p - r_ts,
                                              r_line};
                        b.cnt = b.cnt + 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") n_mode = M_COMMENT;
                    else begin
                        b.tok[b.cnt[1:0]] = '{K_SLASH, r_ts, p - r_ts, r_line};
                        b.cnt = b.cnt + 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_COMMENT: rescan = (c == 8'h0A);
                M_STRING: begin
                    if (c == "\"") begin
                        b.tok[b.cnt[1:0]] = '{K_STRING, r_ts, len_inc(p - r_ts), r_line};
                        b.cnt = b.cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h0A && r_line != 16'hFFFF) begin
                        n_line = r_line + 16'd1;
                    end
                end
                M_NUM: begin
                    if (c == ".") n_mode = M_NUMDOT;
                    else if (!is_digit(c)) begin
                        b.tok[b.cnt[1:0]] = '{K_NUMBER, r_ts, p - r_ts, r_line};
                        b.cnt = b.cnt + 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(c)) n_mode = M_FRAC;
                    else begin
                        dot = (p > r_ts) ? p - 16'd1 : r_ts;
                        b.tok[0] = '{K_NUMBER, r_ts, dot - r_ts, r_line};
                        b.tok[1] = '{K_DOT, dot, 16'd1, r_line};
                        b.cnt = 3'd2;
                        rescan = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(c)) begin
                        b.tok[b.cnt[1:0]] = '{K_NUMBER, r_ts, p - r_ts, r_line};
                        b.cnt = b.cnt + 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        n_kb = {r_kb[39:0], c};
                        if (r_nl != 3'd7) n_nl = r_nl + 3'd1;
                    end else begin
                        b.tok[b.cnt[1:0]] = '{kw_kind(r_kb, r_nl), r_ts, p - r_ts, r_line};
                        b.cnt = b.cnt + 3'd1;
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            // the byte starts a new token from idle
            if (rescan) begin
                n_ts   = p;
                n_mode = M_IDLE;
                unique case (c)
                    "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
                        b.tok[b.cnt[1:0]] = '{
                            (c == "(") ? 6'd0 : (c == ")") ? 6'd1 : (c == "{") ? 6'd2 :
                            (c == "}") ? 6'd3 : (c == ",") ? 6'd4 : (c == ".") ? 6'd5 :
                            (c == "-") ? 6'd6 : (c == "+") ? 6'd7 : (c == ";") ? 6'd8 : 6'd9,
                            p, 16'd1, r_line};
                        b.cnt = b.cnt + 3'd1;
                    end
                    "!", "=", "<", ">": begin
                        n_op = (c == "!") ? 2'd0 : (c == "=") ? 2'd1 :
                               (c == "<") ? 2'd2 : 2'd3;
                        n_mode = M_OP;
                    end
                    "/":  n_mode = M_SLASH;
                    " ", 8'h0D, 8'h09: ;
                    8'h0A: if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                    "\"": n_mode = M_STRING;
                    default: begin
                        if (is_digit(c)) n_mode = M_NUM;
                        else if (is_alpha(c)) begin
                            n_mode = M_IDENT;
                            n_kb   = {40'd0, c};
                            n_nl   = 3'd1;
                        end else begin
                            b.tok[b.cnt[1:0]] = '{K_BADCHAR, p, 16'd1, r_line};
                            b.cnt = b.cnt + 3'd1;
                        end
                    end
                endcase
            end
            if (r_pos < POS_MAX) n_pos = r_pos + 16'd1;
        end

        if (i_last) begin
            p = n_pos;
            unique case (n_mode)
                M_OP: begin
                    b.tok[b.cnt[1:0]] = '{K_OP0 + {3'd0, n_op, 1'b0}, n_ts, p - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                M_SLASH: begin
                    b.tok[b.cnt[1:0]] = '{K_SLASH, n_ts, p - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                M_STRING: begin
                    b.tok[b.cnt[1:0]] = '{K_UNTERM, n_ts, p - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                M_NUM, M_FRAC: begin
                    b.tok[b.cnt[1:0]] = '{K_NUMBER, n_ts, p - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                M_NUMDOT: begin
                    dot = (p > n_ts) ? p - 16'd1 : n_ts;
                    b.tok[b.cnt[1:0]] = '{K_NUMBER, n_ts, dot - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                    b.tok[b.cnt[1:0]] = '{K_DOT, dot, 16'd1, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                M_IDENT: begin
                    b.tok[b.cnt[1:0]] = '{kw_kind(n_kb, n_nl), n_ts, p - n_ts, n_line};
                    b.cnt = b.cnt + 3'd1;
                end
                default: ;
            endcase
            b.tok[b.cnt[1:0]] = '{K_END, p, 16'd0, n_line};
            b.cnt  = b.cnt + 3'd1;
            n_mode = M_IDLE;
            n_pos  = 16'd0;
            n_ts   = 16'd0;
            n_line = 16'd1;
            n_op   = 2'd0;
            n_kb   = 48'd0;
            n_nl   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= 16'd0;
            r_ts   <= 16'd0;
            r_line <= 16'd1;
            r_op   <= 2'd0;
            r_kb   <= 48'd0;
            r_nl   <= 3'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_ts   <= n_ts;
            r_line <= n_line;
            r_op   <= n_op;
            r_kb   <= n_kb;
            r_nl   <= n_nl;
        end
    end

    ap_ts_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ts <= r_pos)
        else $error("token start past position");
    ap_line_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_line != 16'd0)
        else $error("line counter zero");
    ap_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |-> b.cnt != 3'd0 && b.tok[b.cnt[1:0] - 2'd1].kind == K_END)
        else $error("end token missing");
endmodule

/* sv/stl_queue.sv */
// stl_queue: two-entry bundle queue between scanner and token serializer.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stl_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output stl_pkg::t_qwr     o_wr,
    output logic              o_empty,
    output stl_pkg::t_bundle  o_head
);
    import stl_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_wr.push = i_push;
    assign o_wr.full = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_head    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= 2'd2)
        else $error("queue count overflow");
    ap_nofull_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.full |-> !i_push) else $error("push into full queue");
    ap_noempty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
endmodule

/* sv/stl_back.sv */
// stl_back: serializer that sends the tokens of the head bundle one word per cycle while i_ready is high.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  stl_pkg::t_bundle  i_head,
    input  logic              i_ready,
    output logic              o_valid,
    output stl_pkg::t_tok     o_tok,
    output logic              o_last,
    output logic              o_pop
);
    import stl_pkg::*;

    logic [1:0] r_idx;

    assign o_valid = !i_empty;
    assign o_tok   = i_head.tok[r_idx];
    assign o_last  = ({1'b0, r_idx} == i_head.cnt - 3'd1);
    assign o_pop   = o_valid && i_ready && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= 2'd0;
        else if (o_valid && i_ready) r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
    end

    ap_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, r_idx} < i_head.cnt) else $error("token index past bundle");
endmodule

/* sv/script_token_lexer_unit.sv */
// script_token_lexer_unit: top level of the streaming script token lexer.
// Depends on stl_pkg, stl_in_if, stl_out_if, stl_front, stl_queue, stl_back.
//
// Usage: source bytes arrive one word each on i_in (char_code, no_char, is_last);
// tokens leave on o_out (kind, start offset, length, line, last_of_run).
// A word with is_last flushes the open token, then emits an end token, and the
// scanner returns to its reset state for the next source.
// A token is registered in the bundle queue and leaves on o_out from the queue head.
// Throughput: one byte word per cycle while each word causes at most one token;
// a word causing n tokens holds the serializer until all n are sent, the two-entry
// bundle queue absorbs that and input ready drops only when both entries are taken.
// Output ready low stalls the serializer; the scanner keeps accepting words until
// the queue fills, then i_in.ready drops. Nothing is lost or repeated.
// Reset (synchronous, active low): scanner at idle, offset 0, line 1, queue empty.
`timescale 1ns / 1ps
module script_token_lexer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stl_in_if.sink       i_in,
    stl_out_if.source    o_out
);
    import stl_pkg::*;

    t_bundle front_bundle;
    t_bundle head;
    t_qwr    qwr;
    logic    push;
    logic    pop;
    logic    empty;
    t_tok    tok;
    logic    last;

    // front: classify bytes, build token bundles
    stl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_char    (i_in.char_code),
        .i_no_char (i_in.no_char),
        .i_last    (i_in.is_last),
        .i_full    (qwr.full),
        .o_ready   (i_in.ready),
        .o_push    (push),
        .o_bundle  (front_bundle)
    );

    // queue decouples scanning from token delivery
    stl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (front_bundle),
        .i_pop    (pop),
        .o_wr     (qwr),
        .o_empty  (empty),
        .o_head   (head)
    );

    // back: one token per word on the output
    stl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_tok   (tok),
        .o_last  (last),
        .o_pop   (pop)
    );

    assign o_out.token_kind   = tok.kind;
    assign o_out.start_offset = tok.start;
    assign o_out.token_length = tok.len;
    assign o_out.line_number  = tok.line;
    assign o_out.last_of_run  = last;
endmodule

/* test/tb_lexer_scoreboard.sv */
// tb_lexer_scoreboard: token predictor and expected-token store for the lexer testbench.
// Depends on stl_pkg.
`timescale 1ns / 1ps
class lexer_scoreboard;
    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_SLASH, S_COMMENT, S_STRING, S_NUM, S_NUMDOT, S_FRAC, S_IDENT
    } t_scan;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    t_scan       mode;
    logic [15:0] pos;
    logic [15:0] tstart;
    logic [15:0] line;
    logic [1:0]  op;
    logic [47:0] name_buf;
    logic [2:0]  name_len;
    t_token      pending_tokens[$];
    t_token      word_tokens[$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
        clear();
    endfunction

    function void clear();
        mode     = S_IDLE;
        pos      = 0;
        tstart   = 0;
        line     = 1;
        op       = 0;
        name_buf = 0;
        name_len = 0;
    endfunction

    function void put(logic [5:0] kind, logic [15:0] start, int unsigned len);
        t_token t;
        if (word_tokens.size() >= 4) return;
        t.kind  = kind;
        t.start = start;
        t.len   = (len > 65535) ? 16'hFFFF : 16'(len);
        t.line  = line;
        t.last  = 1'b0;
        word_tokens.insert(word_tokens.size(), t);
    endfunction

    function void bump_line();
        if (line != 16'hFFFF) line++;
    endfunction

    function logic [5:0] name_to_kind();
        if (name_len > 6) return stl_pkg::K_IDENT;
        for (int i = 0; i < stl_pkg::NUM_KW; i++)
            if (name_len == stl_pkg::KW_LEN[i] && name_buf == stl_pkg::KW_TEXT[i])
                return 6'(stl_pkg::K_KW0 + i);
        return stl_pkg::K_IDENT;
    endfunction

    static function bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    static function bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void begin_token(logic [7:0] c, logic [15:0] p);
        logic [7:0] punct[10];
        logic [7:0] ops[4];
        punct = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*"};
        ops   = '{"!", "=", "<", ">"};
        tstart = p;
        mode   = S_IDLE;
        for (int k = 0; k < 10; k++)
            if (c == punct[k]) begin
                put(6'(k), p, 1);
                return;
            end
        for (int k = 0; k < 4; k++)
            if (c == ops[k]) begin
                op   = 2'(k);
                mode = S_OP;
                return;
            end
        if (c == "/") mode = S_SLASH;
        else if (c == " " || c == 8'h0D || c == 8'h09) ;
        else if (c == 8'h0A) bump_line();
        else if (c == "\"") mode = S_STRING;
        else if (is_digit(c)) mode = S_NUM;
        else if (is_alpha(c)) begin
            mode     = S_IDENT;
            name_buf = {40'd0, c};
            name_len = 1;
        end else put(stl_pkg::K_BADCHAR, p, 1);
    endfunction

    // Number followed by a dot that no digit joined: number then dot token.
    function void split_dot(logic [15:0] p);
        logic [15:0] dot;
        dot = (p > tstart) ? p - 16'd1 : tstart;
        put(stl_pkg::K_NUMBER, tstart, dot - tstart);
        put(stl_pkg::K_DOT, dot, 1);
    endfunction

    function void scan(logic [7:0] c, logic [15:0] p);
        case (mode)
            S_OP: begin
                if (c == "=") begin
                    put(6'(stl_pkg::K_OPEQ0 + 2 * op), tstart, p - tstart + 1);
                    mode = S_IDLE;
                    return;
                end
                put(6'(stl_pkg::K_OP0 + 2 * op), tstart, p - tstart);
            end
            S_SLASH: begin
                if (c == "/") begin
                    mode = S_COMMENT;
                    return;
                end
                put(stl_pkg::K_SLASH, tstart, p - tstart);
            end
            S_COMMENT: if (c != 8'h0A) return;
            S_STRING: begin
                if (c == "\"") begin
                    put(stl_pkg::K_STRING, tstart, p - tstart + 1);
                    mode = S_IDLE;
                end else if (c == 8'h0A) bump_line();
                return;
            end
            S_NUM: begin
                if (is_digit(c)) return;
                if (c == ".") begin
                    mode = S_NUMDOT;
                    return;
                end
                put(stl_pkg::K_NUMBER, tstart, p - tstart);
            end
            S_NUMDOT: begin
                if (is_digit(c)) begin
                    mode = S_FRAC;
                    return;
                end
                split_dot(p);
            end
            S_FRAC: begin
                if (is_digit(c)) return;
                put(stl_pkg::K_NUMBER, tstart, p - tstart);
            end
            S_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    name_buf = {name_buf[39:0], c};
                    if (name_len < 7) name_len++;
                    return;
                end
                put(name_to_kind(), tstart, p - tstart);
            end
            default: ;
        endcase
        begin_token(c, p);
    endfunction

    function void flush_source();
        case (mode)
            S_OP:           put(6'(stl_pkg::K_OP0 + 2 * op), tstart, pos - tstart);
            S_SLASH:        put(stl_pkg::K_SLASH, tstart, pos - tstart);
            S_STRING:       put(stl_pkg::K_UNTERM, tstart, pos - tstart);
            S_NUM, S_FRAC:  put(stl_pkg::K_NUMBER, tstart, pos - tstart);
            S_NUMDOT:       split_dot(pos);
            S_IDENT:        put(name_to_kind(), tstart, pos - tstart);
            default: ;
        endcase
        put(stl_pkg::K_END, pos, 0);
    endfunction

    // Accepted byte word: predict the tokens it causes.
    function void note_word(logic [7:0] c, logic no_char, logic is_last);
        word_tokens.delete();
        if (pos > stl_pkg::POS_MAX) pos = stl_pkg::POS_MAX;
        if (tstart > pos) tstart = pos;
        if (!no_char) begin
            scan(c, pos);
            if (pos < stl_pkg::POS_MAX) pos++;
        end
        if (is_last) begin
            flush_source();
            clear();
        end
        if (word_tokens.size() > 0) word_tokens[word_tokens.size() - 1].last = 1'b1;
        foreach (word_tokens[i]) pending_tokens.insert(pending_tokens.size(), word_tokens[i]);
    endfunction

    function void check_token(t_token got);
        t_token exp;
        checked++;
        if (pending_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token kind=%0d start=%0d len=%0d line=%0d",
                     $time, got.kind, got.start, got.len, got.line);
            return;
        end
        exp = pending_tokens.pop_front();
        if (got.kind != exp.kind) begin
            errors++;
            $display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
        end
        if (got.start != exp.start) begin
            errors++;
            $display("%0t: start exp %0d got %0d", $time, exp.start, got.start);
        end
        if (got.len != exp.len) begin
            errors++;
            $display("%0t: length exp %0d got %0d", $time, exp.len, got.len);
        end
        if (got.line != exp.line) begin
            errors++;
            $display("%0t: line exp %0d got %0d", $time, exp.line, got.line);
        end
        if (got.last != exp.last) begin
            errors++;
            $display("%0t: last exp %0b got %0b", $time, exp.last, got.last);
        end
    endfunction
endclass

/* test/tb_top.sv */
// tb_top: self-checking testbench of script_token_lexer_unit.
// Depends on stl_pkg, stl_in_if, stl_out_if, the lexer RTL and tb_lexer_scoreboard.
`timescale 1ns / 1ps
module tb_top;
    localparam int IDLE_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;

    stl_in_if  src_if ();
    stl_out_if tok_if ();

    script_token_lexer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_if.sink),
        .o_out   (tok_if.source)
    );

    lexer_scoreboard lex_sb;
    int  words_sent;
    int  stall_cycles;   // long hold-off of the token side, counted in its own process
    bit  stall_done;
    int  quiet_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // One word on the byte side, after a random gap; valid stays up between
    // back-to-back words.
    task automatic send_word(logic [7:0] c, logic nc, logic last, int gap);
        if (gap > 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        src_if.valid     <= 1'b1;
        src_if.char_code <= c;
        src_if.no_char   <= nc;
        src_if.is_last   <= last;
        do @(posedge i_clk); while (!src_if.ready);
        lex_sb.note_word(c, nc, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit last, bit fast);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0, last && i == s.len() - 1,
                      fast ? 0 : $urandom_range(0, 12) * ($urandom_range(0, 3) == 0));
    endtask

    // Random bytes weighted toward the lexer's classes.
    function automatic logic [7:0] rand_byte();
        string pool;
        pool = "abcdefrnuilsvhtwoxyzAZ_0123456789.;=!<>/\"\n \t(){},-+*";
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(0, 1) ? 8'hFF : 8'h80);
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    function automatic string rand_lexeme();
        string kws[17];
        kws = '{"and", "class", "false", "fun", "for", "while", "if", "else", "nil",
                "or", "print", "return", "super", "this", "true", "var", "break"};
        case ($urandom_range(0, 9))
            0, 1:    return {kws[$urandom_range(0, 16)], " "};
            2:       return "12.5 ";
            3:       return "\"s\ntr\" ";
            4:       return "a<=b!=c ";
            5:       return "// note\n";
            6:       return "7. x ";
            7:       return "longername1 ";
            default: return {string'(rand_byte()), string'(rand_byte())};
        endcase
    endfunction

    task automatic wait_drain();
        src_if.valid <= 1'b0;
        while (lex_sb.pending_tokens.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Token side: a drawn wait before each word, one long hold-off when asked.
    initial begin
        int tok_wait;
        bit took;
        bit rdy;
        tok_wait = 0;
        took     = 1'b0;
        tok_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (took) tok_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
            if (stall_cycles > 0) begin
                rdy = 1'b0;
                stall_cycles--;
            end else if (words_sent > 150 && words_sent < 200) rdy = 1'b1;
            else if (tok_wait > 0) begin
                rdy = 1'b0;
                tok_wait--;
            end else rdy = 1'b1;
            tok_if.ready <= rdy;
            took = tok_if.valid && rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tok_if.valid && tok_if.ready)
            lex_sb.check_token('{tok_if.token_kind, tok_if.start_offset,
                                 tok_if.token_length, tok_if.line_number,
                                 tok_if.last_of_run});
    end

    // Watchdog: cycles without any handshake.
    always @(posedge i_clk) begin
        if ((src_if.valid && src_if.ready) || (tok_if.valid && tok_if.ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT && i_rst_n) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        lex_sb       = new();
        words_sent   = 0;
        stall_cycles = 0;
        stall_done   = 0;
        quiet_cycles = 0;
        i_rst_n          = 1'b0;
        src_if.valid     = 1'b0;
        src_if.char_code = 8'h00;
        src_if.no_char   = 1'b0;
        src_if.is_last   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: punctuation, operators, comment, string, numbers, keywords.
        send_text("(){},.-+;*!!=", 0, 0);
        send_text("=<=<>=>/ //c\n", 0, 0);
        send_text("\"a\nb\" 1.5 7.x ", 0, 0);
        send_text("while whiles _Z9 @", 1, 0);
        send_word(8'h00, 1'b1, 1'b0, 0);     // no byte, not last: ignored
        send_word(8'h00, 1'b1, 1'b1, 0);     // empty source
        send_text("\"open", 1, 0);           // unterminated string
        send_text("12.", 1, 0);              // dot at end of source
        wait_drain();                        // sender pause until all tokens are out

        // Random sources; a burst of one-token-per-byte words under a long stall.
        while (words_sent < 265) begin
            if (words_sent > 120 && !stall_done) begin
                stall_done   = 1;
                stall_cycles = 60;
                send_text("(((((((((((((((((((((", 0, 1);
            end
            if ($urandom_range(0, 25) == 0) send_word(rand_byte(), 1'b0, 1'b1, 0);
            else send_text(rand_lexeme(), 0, 0);
        end
        send_word(8'h00, 1'b1, 1'b1, 0);
        wait_drain();
        repeat (20) @(negedge i_clk);

        $display("Sent %0d byte words; checked %0d tokens across punctuation, operators,",
                 words_sent, lex_sb.checked);
        $display("comments, strings, numbers, names, keywords, errors and end flushes.");
        if (lex_sb.errors == 0 && lex_sb.pending_tokens.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
